FILE: rtl/mdwm_pkg.sv
package mdwm_pkg;

    // Fixed point: 1.0 is 2^FRAC_BITS
    localparam int FRAC_BITS       = 15;
    localparam int ONE_VAL         = 1 << FRAC_BITS;
    localparam int MAX_WHEEL_SPEED = 89;
    localparam int INV_ROOT2       = 23170;
    localparam int PIVOT_SHORT     = 13171;
    localparam int PIVOT_MID       = 19063;
    localparam int PIVOT_LONG      = 32768;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_W      = 23;

    typedef logic signed [16:0] axis_t;     // shaped axis, +-1.0
    typedef logic signed [17:0] rot_t;      // rotated axis
    typedef logic signed [19:0] wheel_t;    // raw wheel before normalizing
    typedef wheel_t [3:0]       wheel_vec_t;
    typedef logic signed [16:0] nwheel_t;   // normalized wheel, +-1.0
    typedef nwheel_t [3:0]      nwheel_vec_t;
    typedef logic [33:0]        radicand_t;
    typedef logic [17:0]        root_t;
    typedef logic [19:0]        wmag_t;

    typedef enum logic [2:0] {
        MODE_OMNI     = 3'd0,
        MODE_STRAFE   = 3'd1,
        MODE_ARCADE   = 3'd2,
        MODE_FL_PIVOT = 3'd3,
        MODE_FR_PIVOT = 3'd4,
        MODE_RL_PIVOT = 3'd5,
        MODE_RR_PIVOT = 3'd6
    } drive_mode_t;

    typedef enum logic [2:0] {
        CFG_SQUARED_INPUTS  = 3'd0,
        CFG_DEADBAND        = 3'd1,
        CFG_DRIVE_MODE      = 3'd2,
        CFG_SPEED_LOOP_MODE = 3'd3,
        CFG_INVERT_MASK     = 3'd4,
        CFG_MAX_OUTPUT      = 3'd5
    } cfg_index_t;

    // Quarter-wave sine table, steps of pi/64
    function automatic logic [15:0] quarter_sine(input logic [5:0] idx);
        case (idx)
            6'd0:  quarter_sine = 16'd0;
            6'd1:  quarter_sine = 16'd1608;
            6'd2:  quarter_sine = 16'd3212;
            6'd3:  quarter_sine = 16'd4808;
            6'd4:  quarter_sine = 16'd6393;
            6'd5:  quarter_sine = 16'd7962;
            6'd6:  quarter_sine = 16'd9512;
            6'd7:  quarter_sine = 16'd11039;
            6'd8:  quarter_sine = 16'd12540;
            6'd9:  quarter_sine = 16'd14010;
            6'd10: quarter_sine = 16'd15447;
            6'd11: quarter_sine = 16'd16846;
            6'd12: quarter_sine = 16'd18205;
            6'd13: quarter_sine = 16'd19520;
            6'd14: quarter_sine = 16'd20788;
            6'd15: quarter_sine = 16'd22006;
            6'd16: quarter_sine = 16'd23170;
            6'd17: quarter_sine = 16'd24279;
            6'd18: quarter_sine = 16'd25330;
            6'd19: quarter_sine = 16'd26320;
            6'd20: quarter_sine = 16'd27246;
            6'd21: quarter_sine = 16'd28106;
            6'd22: quarter_sine = 16'd28899;
            6'd23: quarter_sine = 16'd29622;
            6'd24: quarter_sine = 16'd30274;
            6'd25: quarter_sine = 16'd30853;
            6'd26: quarter_sine = 16'd31357;
            6'd27: quarter_sine = 16'd31786;
            6'd28: quarter_sine = 16'd32138;
            6'd29: quarter_sine = 16'd32413;
            6'd30: quarter_sine = 16'd32610;
            6'd31: quarter_sine = 16'd32729;
            6'd32: quarter_sine = 16'd32768;
            default: quarter_sine = 16'd0;
        endcase
    endfunction

    // Sine of a binary angle, interpolated over the low 9 bits
    function automatic axis_t sine_q15(input logic [15:0] a);
        logic [1:0]  quad;
        logic [14:0] p;
        logic [5:0]  idx;
        logic [8:0]  frac;
        logic [15:0] base;
        logic [15:0] nxt;
        logic [20:0] interp;
        logic [16:0] s;
        quad = a[15:14];
        p    = {1'b0, a[13:0]};
        if (quad[0])
        begin
            p = 15'd16384 - p;
        end
        idx  = p[14:9];
        frac = p[8:0];
        base = quarter_sine(idx);
        nxt  = quarter_sine(idx + 6'd1);
        if (idx >= 6'd32)
        begin
            s = 17'd32768;
        end
        else
        begin
            interp = (21'(nxt - base) * 21'(frac) + 21'd256) >> 9;
            s      = 17'(base) + 17'(interp);
        end
        sine_q15 = quad[1] ? -$signed(s) : $signed(s);
    endfunction

    // Shift right by FRAC_BITS, rounding half away from zero
    function automatic logic signed [47:0] round_frac(input logic signed [47:0] v);
        logic [47:0] m;
        m = v[47] ? 48'(-v) : 48'(v);
        m = (m + (48'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        round_frac = v[47] ? -$signed(m) : $signed(m);
    endfunction

endpackage

FILE: rtl/mdwm_isqrt.sv
module mdwm_isqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  mdwm_pkg::radicand_t    radicand,
    input  mdwm_pkg::wheel_vec_t   side_in,
    output logic                   out_valid,
    output mdwm_pkg::root_t        root,
    output mdwm_pkg::wheel_vec_t   side_out
);
    import mdwm_pkg::*;

    // One result bit per stage, top test bit 2^32
    localparam int STAGES = 17;

    logic              valid_reg [STAGES];
    logic [35:0]       n_reg     [STAGES];
    logic [35:0]       r_reg     [STAGES];
    wheel_vec_t        side_reg  [STAGES];

    logic              valid_src [STAGES];
    logic [35:0]       n_src     [STAGES];
    logic [35:0]       r_src     [STAGES];
    wheel_vec_t        side_src  [STAGES];
    logic [35:0]       n_next    [STAGES];
    logic [35:0]       r_next    [STAGES];

    assign valid_src[0] = in_valid;
    assign n_src[0]     = 36'(radicand);
    assign r_src[0]     = '0;
    assign side_src[0]  = side_in;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_stage
            localparam logic [35:0] BIT = 36'(1) << (32 - 2 * k);
            if (k > 0)
            begin : g_link
                assign valid_src[k] = valid_reg[k-1];
                assign n_src[k]     = n_reg[k-1];
                assign r_src[k]     = r_reg[k-1];
                assign side_src[k]  = side_reg[k-1];
            end

            // restoring square root step
            always_comb
            begin
                if (n_src[k] >= r_src[k] + BIT)
                begin
                    n_next[k] = n_src[k] - (r_src[k] + BIT);
                    r_next[k] = (r_src[k] >> 1) + BIT;
                end
                else
                begin
                    n_next[k] = n_src[k];
                    r_next[k] = r_src[k] >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    valid_reg[k] <= valid_src[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    n_reg[k]    <= n_next[k];
                    r_reg[k]    <= r_next[k];
                    side_reg[k] <= side_src[k];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES-1];
    assign root      = r_reg[STAGES-1][17:0];
    assign side_out  = side_reg[STAGES-1];

endmodule

FILE: rtl/mdwm_norm_div.sv
module mdwm_norm_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  mdwm_pkg::wheel_vec_t   in_wheels,
    input  mdwm_pkg::wmag_t        in_largest,
    output logic                   out_valid,
    output mdwm_pkg::nwheel_vec_t  out_wheels
);
    import mdwm_pkg::*;

    // One quotient bit per stage: wheel * 1.0 / largest
    localparam int QBITS = 16;

    logic              valid_reg [QBITS];
    wmag_t             d_reg     [QBITS];
    logic              need_reg  [QBITS];
    logic [3:0]        neg_reg   [QBITS];
    nwheel_vec_t       orig_reg  [QBITS];
    logic [3:0][20:0]  rem_reg   [QBITS];
    logic [3:0][15:0]  q_reg     [QBITS];

    logic              valid_src [QBITS];
    wmag_t             d_src     [QBITS];
    logic              need_src  [QBITS];
    logic [3:0]        neg_src   [QBITS];
    nwheel_vec_t       orig_src  [QBITS];
    logic [3:0][20:0]  rem_src   [QBITS];
    logic [3:0][15:0]  q_src     [QBITS];
    logic [3:0][20:0]  rem_next  [QBITS];
    logic [3:0][15:0]  q_next    [QBITS];

    logic              out_valid_reg;
    nwheel_vec_t       out_wheels_reg;
    nwheel_vec_t       out_wheels_next;

    // stage 0 inputs: magnitudes and signs
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg_src[0][i]  = in_wheels[i][19];
            rem_src[0][i]  = in_wheels[i][19] ? 21'(-in_wheels[i]) : 21'(in_wheels[i]);
            orig_src[0][i] = nwheel_t'(in_wheels[i]);
        end
    end
    assign valid_src[0] = in_valid;
    assign d_src[0]     = in_largest;
    assign need_src[0]  = in_largest > wmag_t'(ONE_VAL);
    assign q_src[0]     = '0;

    genvar j;
    generate
        for (j = 0; j < QBITS; j++)
        begin : g_stage
            if (j > 0)
            begin : g_link
                assign valid_src[j] = valid_reg[j-1];
                assign d_src[j]     = d_reg[j-1];
                assign need_src[j]  = need_reg[j-1];
                assign neg_src[j]   = neg_reg[j-1];
                assign orig_src[j]  = orig_reg[j-1];
                assign rem_src[j]   = rem_reg[j-1];
                assign q_src[j]     = q_reg[j-1];
            end

            // compare and subtract, then bring down a zero
            always_comb
            begin
                for (int i = 0; i < 4; i++)
                begin
                    q_next[j][i] = q_src[j][i];
                    if (rem_src[j][i] >= 21'(d_src[j]))
                    begin
                        q_next[j][i][QBITS-1-j] = 1'b1;
                        rem_next[j][i] = (rem_src[j][i] - 21'(d_src[j])) << 1;
                    end
                    else
                    begin
                        rem_next[j][i] = rem_src[j][i] << 1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j] <= 1'b0;
                end
                else if (adv)
                begin
                    valid_reg[j] <= valid_src[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    d_reg[j]    <= d_src[j];
                    need_reg[j] <= need_src[j];
                    neg_reg[j]  <= neg_src[j];
                    orig_reg[j] <= orig_src[j];
                    rem_reg[j]  <= rem_next[j];
                    q_reg[j]    <= q_next[j];
                end
            end
        end
    endgenerate

    // restore signs, or pass wheels through when none exceeds 1.0
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (need_reg[QBITS-1])
            begin
                out_wheels_next[i] = neg_reg[QBITS-1][i]
                                   ? -$signed({1'b0, q_reg[QBITS-1][i]})
                                   : $signed({1'b0, q_reg[QBITS-1][i]});
            end
            else
            begin
                out_wheels_next[i] = orig_reg[QBITS-1][i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= valid_reg[QBITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_wheels_reg <= out_wheels_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_wheels = out_wheels_reg;

endmodule

FILE: rtl/mecanum_drive_wheel_mixer_unit.sv
// Mecanum wheel mixer: one stick request (x, y, rotation, gyro heading) in,
// four wheel values out. Fully pipelined: a new request can be taken every
// cycle, and each request passes through 5 shaping and rotation stages, 17
// square-root stages, 5 pivot and peak stages, 17 normalizing divide
// stages, 2 gain stages and the output register. The whole pipe moves
// together; it holds when the output register is full and not taken, so
// in_ready follows out_ready. Configuration registers may only be written
// while no request is in flight.
module mecanum_drive_wheel_mixer_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [mdwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mdwm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [15:0]                 x_speed,
    input  logic signed [15:0]                 y_speed,
    input  logic signed [15:0]                 turn_rate,
    input  logic [15:0]                        gyro_angle,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mdwm_pkg::OUT_W-1:0]  front_left_value,
    output logic signed [mdwm_pkg::OUT_W-1:0]  front_right_value,
    output logic signed [mdwm_pkg::OUT_W-1:0]  rear_left_value,
    output logic signed [mdwm_pkg::OUT_W-1:0]  rear_right_value,
    output logic                               to_speed_loop
);
    import mdwm_pkg::*;

    // configuration
    logic              squared_inputs_reg;
    logic [15:0]       deadband_reg;
    drive_mode_t       drive_mode_reg;
    logic              speed_loop_mode_reg;
    logic [3:0]        invert_mask_reg;
    logic [15:0]       max_output_reg;

    logic              adv;

    // stage registers
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    axis_t             s1_x_reg, s1_y_reg, s1_r_reg, s1_sn_reg, s1_cs_reg;
    logic signed [33:0] s2_xc_reg, s2_ys_reg, s2_xs_reg, s2_yc_reg;
    axis_t             s2_r_reg, s3_r_reg, s4_r_reg;
    rot_t              s3_xr_reg, s3_yr_reg, s4_xr_reg, s4_yr_reg;
    logic signed [35:0] s4_xx_reg, s4_yy_reg;
    logic signed [34:0] s4_a_reg, s4_b_reg, s4_xk_reg;
    radicand_t         s5_rad_reg;
    wheel_vec_t        s5_w_reg, s5_w_next;

    logic              sq_valid;
    root_t             sq_root;
    wheel_vec_t        sq_w;

    logic              p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg, p5_valid_reg;
    root_t             p1_h_reg;
    logic signed [33:0] p1_hk_reg;
    logic signed [18:0] p2_hh_reg;
    logic signed [36:0] p3_prod_reg [4];
    wheel_vec_t        p1_w_reg, p2_w_reg, p3_w_reg, p4_w_reg, p5_w_reg;
    wmag_t             p5_largest_reg, p5_largest_next;
    logic              pivot;

    logic              nv_valid;
    nwheel_vec_t       nv_w;

    logic              g1_valid_reg, g2_valid_reg, out_valid_reg;
    logic signed [33:0] g1_reg [4];
    logic signed [40:0] g2_reg [4];
    logic [16:0]       gain;
    logic signed [OUT_W-1:0] out_value_reg [4];
    logic              to_speed_loop_reg;

    // Sign-kept squaring and deadband; 16-bit input is already within +-1.0
    function automatic axis_t shape_axis(input logic [15:0] raw, input logic sq,
                                         input logic [15:0] db);
        logic signed [16:0] v;
        logic [16:0]        m;
        logic [33:0]        p;
        v = 17'($signed(raw));
        m = v[16] ? 17'(-v) : 17'(v);
        if (sq)
        begin
            p = 34'(m) * 34'(m) + 34'(ONE_VAL / 2);
            m = 17'(p >> FRAC_BITS);
        end
        if (m < 17'(db))
        begin
            m = '0;
        end
        shape_axis = v[16] ? -$signed(m) : $signed(m);
    endfunction

    // Pivot coefficient for one wheel
    function automatic logic signed [17:0] pivot_coef(input drive_mode_t md,
                                                      input int idx);
        logic signed [17:0] c;
        c = '0;
        case (md)
            MODE_FL_PIVOT:
            begin
                if (idx == 1) c = -18'(PIVOT_SHORT);
                if (idx == 2) c = -18'(PIVOT_MID);
                if (idx == 3) c = -18'(PIVOT_LONG);
            end
            MODE_FR_PIVOT:
            begin
                if (idx == 0) c = 18'(PIVOT_SHORT);
                if (idx == 2) c = 18'(PIVOT_LONG);
                if (idx == 3) c = 18'(PIVOT_MID);
            end
            MODE_RL_PIVOT:
            begin
                if (idx == 0) c = -18'(PIVOT_MID);
                if (idx == 1) c = -18'(PIVOT_LONG);
                if (idx == 3) c = -18'(PIVOT_SHORT);
            end
            MODE_RR_PIVOT:
            begin
                if (idx == 0) c = 18'(PIVOT_LONG);
                if (idx == 1) c = 18'(PIVOT_MID);
                if (idx == 2) c = 18'(PIVOT_SHORT);
            end
            default: c = '0;
        endcase
        pivot_coef = c;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            squared_inputs_reg  <= 1'b0;
            deadband_reg        <= '0;
            drive_mode_reg      <= MODE_OMNI;
            speed_loop_mode_reg <= 1'b1;
            invert_mask_reg     <= '0;
            max_output_reg      <= 16'(ONE_VAL);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_SQUARED_INPUTS:  squared_inputs_reg  <= cfg_data[0];
                CFG_DEADBAND:        deadband_reg        <= cfg_data;
                CFG_DRIVE_MODE:      drive_mode_reg      <= drive_mode_t'(cfg_data[2:0]);
                CFG_SPEED_LOOP_MODE: speed_loop_mode_reg <= cfg_data[0];
                CFG_INVERT_MASK:     invert_mask_reg     <= cfg_data[3:0];
                CFG_MAX_OUTPUT:      max_output_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe advances unless the output holds an untaken request
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            p5_valid_reg  <= 1'b0;
            g1_valid_reg  <= 1'b0;
            g2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            p1_valid_reg  <= sq_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            p5_valid_reg  <= p4_valid_reg;
            g1_valid_reg  <= nv_valid;
            g2_valid_reg  <= g1_valid_reg;
            out_valid_reg <= g2_valid_reg;
        end
    end

    // front end: shaping, heading rotation, mix products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // S1: shape axes, look up sin and cos
            s1_x_reg  <= shape_axis(x_speed, squared_inputs_reg, deadband_reg);
            s1_y_reg  <= shape_axis(y_speed, squared_inputs_reg, deadband_reg);
            s1_r_reg  <= shape_axis(turn_rate, squared_inputs_reg, deadband_reg);
            s1_sn_reg <= sine_q15(gyro_angle);
            s1_cs_reg <= sine_q15(gyro_angle + 16'd16384);
            // S2: rotation products
            s2_xc_reg <= 34'(s1_x_reg) * 34'(s1_cs_reg);
            s2_ys_reg <= 34'(s1_y_reg) * 34'(s1_sn_reg);
            s2_xs_reg <= 34'(s1_x_reg) * 34'(s1_sn_reg);
            s2_yc_reg <= 34'(s1_y_reg) * 34'(s1_cs_reg);
            s2_r_reg  <= s1_r_reg;
            // S3: rotated x and y
            s3_xr_reg <= rot_t'(round_frac(48'(s2_xc_reg - s2_ys_reg)));
            s3_yr_reg <= rot_t'(round_frac(48'(s2_xs_reg + s2_yc_reg)));
            s3_r_reg  <= s2_r_reg;
            // S4: squares for the stick magnitude, 0.7071 mixes
            s4_xx_reg <= 36'(s3_xr_reg) * 36'(s3_xr_reg);
            s4_yy_reg <= 36'(s3_yr_reg) * 36'(s3_yr_reg);
            s4_a_reg  <= 35'(19'(s3_xr_reg) - 19'(s3_yr_reg)) * 35'(INV_ROOT2);
            s4_b_reg  <= 35'(19'(s3_xr_reg) + 19'(s3_yr_reg)) * 35'(INV_ROOT2);
            s4_xk_reg <= 35'(s3_xr_reg) * 35'(INV_ROOT2);
            s4_xr_reg <= s3_xr_reg;
            s4_yr_reg <= s3_yr_reg;
            s4_r_reg  <= s3_r_reg;
            // S5
            s5_rad_reg <= radicand_t'(s4_xx_reg + s4_yy_reg);
            s5_w_reg   <= s5_w_next;
        end
    end

    // S5: linear and arcade wheel vectors
    always_comb
    begin
        wheel_t ra, rb, rk, rr, xr, yr, left, right;
        ra    = wheel_t'(round_frac(48'(s4_a_reg)));
        rb    = wheel_t'(round_frac(48'(s4_b_reg)));
        rk    = wheel_t'(round_frac(48'(s4_xk_reg)));
        rr    = wheel_t'(s4_r_reg);
        xr    = wheel_t'(s4_xr_reg);
        yr    = wheel_t'(s4_yr_reg);
        left  = '0;
        right = '0;
        if (yr > 0)
        begin
            if (xr > 0)
            begin
                left  = yr - xr;
                right = (yr > xr) ? yr : xr;
            end
            else
            begin
                left  = (yr > -xr) ? yr : -xr;
                right = yr + xr;
            end
        end
        else
        begin
            if (xr > 0)
            begin
                left  = (-yr > xr) ? yr : -xr;
                right = yr + xr;
            end
            else
            begin
                left  = yr - xr;
                right = (-yr > -xr) ? yr : xr;
            end
        end
        case (drive_mode_reg)
            MODE_OMNI:
            begin
                s5_w_next[0] = ra + rr;
                s5_w_next[1] = rb + rr;
                s5_w_next[2] = rr - rb;
                s5_w_next[3] = rr - ra;
            end
            MODE_STRAFE:
            begin
                s5_w_next[0] = rk + rr;
                s5_w_next[1] = rk + rr;
                s5_w_next[2] = rr - rk;
                s5_w_next[3] = rr - rk;
            end
            MODE_ARCADE:
            begin
                s5_w_next[0] = left;
                s5_w_next[1] = right;
                s5_w_next[2] = left;
                s5_w_next[3] = right;
            end
            default: s5_w_next = '0;
        endcase
    end

    // stick magnitude
    mdwm_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s5_valid_reg),
        .radicand  (s5_rad_reg),
        .side_in   (s5_w_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_w)
    );

    // pivot modes and peak magnitude
    always_comb
    begin
        wmag_t m0, m1, m2, m3, ma, mb;
        pivot = (drive_mode_reg == MODE_FL_PIVOT) || (drive_mode_reg == MODE_FR_PIVOT)
             || (drive_mode_reg == MODE_RL_PIVOT) || (drive_mode_reg == MODE_RR_PIVOT);
        m0 = p4_w_reg[0][19] ? wmag_t'(-p4_w_reg[0]) : wmag_t'(p4_w_reg[0]);
        m1 = p4_w_reg[1][19] ? wmag_t'(-p4_w_reg[1]) : wmag_t'(p4_w_reg[1]);
        m2 = p4_w_reg[2][19] ? wmag_t'(-p4_w_reg[2]) : wmag_t'(p4_w_reg[2]);
        m3 = p4_w_reg[3][19] ? wmag_t'(-p4_w_reg[3]) : wmag_t'(p4_w_reg[3]);
        ma = (m0 > m1) ? m0 : m1;
        mb = (m2 > m3) ? m2 : m3;
        p5_largest_next = (ma > mb) ? ma : mb;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // P1: rr pivot scales the magnitude by 0.7071
            p1_h_reg  <= sq_root;
            p1_hk_reg <= 34'($signed({1'b0, sq_root})) * 34'(INV_ROOT2);
            p1_w_reg  <= sq_w;
            // P2
            p2_hh_reg <= (drive_mode_reg == MODE_RR_PIVOT)
                       ? 19'(round_frac(48'(p1_hk_reg)))
                       : $signed({1'b0, p1_h_reg});
            p2_w_reg  <= p1_w_reg;
            // P3: fixed vector times magnitude
            for (int i = 0; i < 4; i++)
            begin
                p3_prod_reg[i] <= 37'(pivot_coef(drive_mode_reg, i)) * 37'(p2_hh_reg);
            end
            p3_w_reg  <= p2_w_reg;
            // P4
            for (int i = 0; i < 4; i++)
            begin
                p4_w_reg[i] <= pivot ? wheel_t'(round_frac(48'(p3_prod_reg[i])))
                                     : p3_w_reg[i];
            end
            // P5
            p5_w_reg       <= p4_w_reg;
            p5_largest_reg <= p5_largest_next;
        end
    end

    // scale down when any wheel exceeds 1.0
    mdwm_norm_div u_norm_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (p5_valid_reg),
        .in_wheels  (p5_w_reg),
        .in_largest (p5_largest_reg),
        .out_valid  (nv_valid),
        .out_wheels (nv_w)
    );

    // gain, speed scale, rounding and per-motor sign
    assign gain = (max_output_reg > 16'(ONE_VAL)) ? 17'(ONE_VAL) : 17'(max_output_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                g1_reg[i] <= 34'(nv_w[i]) * 34'($signed({1'b0, gain}));
                g2_reg[i] <= speed_loop_mode_reg ? 41'(g1_reg[i]) * 41'(MAX_WHEEL_SPEED)
                                                 : 41'(g1_reg[i]);
                out_value_reg[i] <= invert_mask_reg[i]
                                  ? -OUT_W'(round_frac(48'(g2_reg[i])))
                                  : OUT_W'(round_frac(48'(g2_reg[i])));
            end
            to_speed_loop_reg <= speed_loop_mode_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign front_left_value  = out_value_reg[0];
    assign front_right_value = out_value_reg[1];
    assign rear_left_value   = out_value_reg[2];
    assign rear_right_value  = out_value_reg[3];
    assign to_speed_loop     = to_speed_loop_reg;

    // normalized wheels never exceed 1.0, checked on front left and rear right
    a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nv_valid |-> (nv_w[0] <= 17'sd32768 && nv_w[0] >= -17'sd32768 &&
                      nv_w[3] <= 17'sd32768 && nv_w[3] >= -17'sd32768))
        else $error("normalized wheel out of range");

    // stick magnitude stays below 2^17
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid |-> (sq_root[17] == 1'b0))
        else $error("stick magnitude overflow");

    // results stay within the speed setpoint range, checked on front left and rear right
    a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (front_left_value <= 23'sd2916352 &&
                           front_left_value >= -23'sd2916352 &&
                           rear_right_value <= 23'sd2916352 &&
                           rear_right_value >= -23'sd2916352))
        else $error("wheel value out of range");

endmodule

FILE: dv/testbench.sv
module testbench;
    import mdwm_pkg::*;

    localparam logic [2:0] MODE_UNUSED   = 3'd7;
    localparam logic [2:0] CFG_SPARE_LO  = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI  = 3'd7;
    localparam int         IDLE_LIMIT    = 3000;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         PHASES        = 12;
    localparam int         REQS_PER_PHASE = 50;

    // Expected wheel values of one request
    typedef struct {
        logic signed [OUT_W-1:0] wheel [4];
        logic                    spd;
    } wheel_set_t;

    // Directed stimulus row; typed rows carry one value for all four wheels
    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] r;
        logic [15:0] g;
        bit          typed;
        int          val;
    } stim_row_t;

    localparam int SINE_TAB [33] = '{
        0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
        12540, 14010, 15447, 16846, 18205, 19520, 20788, 22006,
        23170, 24279, 25330, 26320, 27246, 28106, 28899, 29622,
        30274, 30853, 31357, 31786, 32138, 32413, 32610, 32729,
        32768
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic signed [15:0]     x_speed = '0;
    logic signed [15:0]     y_speed = '0;
    logic signed [15:0]     turn_rate = '0;
    logic [15:0]            gyro_angle = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic signed [OUT_W-1:0] front_left_value;
    logic signed [OUT_W-1:0] front_right_value;
    logic signed [OUT_W-1:0] rear_left_value;
    logic signed [OUT_W-1:0] rear_right_value;
    logic                   to_speed_loop;

    // Typed expectation travels with the payload
    logic                   typed_en = 1'b0;
    int                     typed_val = 0;

    // Shadow of the configuration registers
    logic        sh_squared = 1'b0;
    logic [15:0] sh_deadband = '0;
    logic [2:0]  sh_mode = MODE_OMNI;
    logic        sh_speed_loop = 1'b1;
    logic [3:0]  sh_invert = '0;
    logic [15:0] sh_gain = 16'd32768;

    wheel_set_t  wheel_q [$];
    int          err_cnt = 0;
    int          req_cnt = 0;
    int          res_cnt = 0;
    int          idle_cnt = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;
    bit [7:0]    modes_seen = '0;

    mecanum_drive_wheel_mixer_unit DUT (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic longint rnd_shift(longint v, int n);
        longint half;
        half = longint'(1) << (n - 1);
        if (v >= 0)
            return (v + half) >>> n;
        return -((-v + half) >>> n);
    endfunction

    function automatic longint abs_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint shape_axis(logic [15:0] raw);
        longint v;
        longint m;
        v = longint'($signed(raw));
        if (v < -longint'(ONE_VAL))
            v = -longint'(ONE_VAL);
        if (sh_squared)
        begin
            m = abs_of(v);
            m = (m * m + (ONE_VAL >> 1)) >>> FRAC_BITS;
            v = (v < 0) ? -m : m;
        end
        if (abs_of(v) < longint'(sh_deadband))
            v = 0;
        return v;
    endfunction

    function automatic longint heading_sine(logic [15:0] a);
        logic [1:0] quad;
        int         p;
        int         idx;
        int         frac;
        longint     s;
        quad = a[15:14];
        p    = a[13:0];
        if (quad[0])
            p = 16384 - p;
        idx  = p >> 9;
        frac = p & 511;
        if (idx >= 32)
            s = SINE_TAB[32];
        else
            s = SINE_TAB[idx] +
                (((longint'(SINE_TAB[idx + 1]) - SINE_TAB[idx]) * frac + 256) >>> 9);
        return quad[1] ? -s : s;
    endfunction

    function automatic longint root_floor(longint n);
        longint rt;
        longint b;
        rt = 0;
        b  = longint'(1) << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= rt + b)
            begin
                n  = n - (rt + b);
                rt = (rt >> 1) + b;
            end
            else
                rt = rt >> 1;
            b = b >> 2;
        end
        return rt;
    endfunction

    function automatic wheel_set_t mix_request(logic [15:0] xs, logic [15:0] ys,
                                               logic [15:0] rs, logic [15:0] ga);
        longint     x, y, r, sn, cs, xr, yr, h, largest, gain, v, m, left, right;
        longint     w [4];
        longint     pv [4];
        bit         pivot;
        wheel_set_t res;
        x = shape_axis(xs);
        y = shape_axis(ys);
        r = shape_axis(rs);
        sn = heading_sine(ga);
        cs = heading_sine(ga + 16'd16384);
        xr = rnd_shift(x * cs - y * sn, 15);
        yr = rnd_shift(x * sn + y * cs, 15);
        h  = root_floor(xr * xr + yr * yr);
        w  = '{0, 0, 0, 0};
        pv = '{0, 0, 0, 0};
        pivot = 1'b0;
        case (sh_mode)
            MODE_OMNI:
            begin
                w[0] = rnd_shift((xr - yr) * INV_ROOT2, 15) + r;
                w[1] = rnd_shift((xr + yr) * INV_ROOT2, 15) + r;
                w[2] = rnd_shift(-(xr + yr) * INV_ROOT2, 15) + r;
                w[3] = rnd_shift((yr - xr) * INV_ROOT2, 15) + r;
            end
            MODE_STRAFE:
            begin
                w[0] = rnd_shift(xr * INV_ROOT2, 15) + r;
                w[1] = w[0];
                w[2] = rnd_shift(-xr * INV_ROOT2, 15) + r;
                w[3] = w[2];
            end
            MODE_ARCADE:
            begin
                if (yr > 0)
                begin
                    if (xr > 0)
                    begin
                        left  = yr - xr;
                        right = (yr > xr) ? yr : xr;
                    end
                    else
                    begin
                        left  = (yr > -xr) ? yr : -xr;
                        right = yr + xr;
                    end
                end
                else
                begin
                    if (xr > 0)
                    begin
                        left  = -((-yr > xr) ? -yr : xr);
                        right = yr + xr;
                    end
                    else
                    begin
                        left  = yr - xr;
                        right = -((-yr > -xr) ? -yr : -xr);
                    end
                end
                w = '{left, right, left, right};
            end
            MODE_FL_PIVOT:
            begin
                pv = '{0, -PIVOT_SHORT, -PIVOT_MID, -PIVOT_LONG};
                pivot = 1'b1;
            end
            MODE_FR_PIVOT:
            begin
                pv = '{PIVOT_SHORT, 0, PIVOT_LONG, PIVOT_MID};
                pivot = 1'b1;
            end
            MODE_RL_PIVOT:
            begin
                pv = '{-PIVOT_MID, -PIVOT_LONG, 0, -PIVOT_SHORT};
                pivot = 1'b1;
            end
            MODE_RR_PIVOT:
            begin
                pv = '{PIVOT_LONG, PIVOT_MID, PIVOT_SHORT, 0};
                h = rnd_shift(h * INV_ROOT2, 15);
                pivot = 1'b1;
            end
            default:
                w = '{0, 0, 0, 0};
        endcase
        if (pivot)
            for (int k = 0; k < 4; k++)
                w[k] = rnd_shift(pv[k] * h, 15);

        // scale down when any wheel exceeds one
        largest = 0;
        for (int k = 0; k < 4; k++)
            if (abs_of(w[k]) > largest)
                largest = abs_of(w[k]);
        if (largest > ONE_VAL)
            for (int k = 0; k < 4; k++)
            begin
                m = (abs_of(w[k]) * ONE_VAL) / largest;
                w[k] = (w[k] < 0) ? -m : m;
            end

        gain = (sh_gain > ONE_VAL) ? ONE_VAL : sh_gain;
        for (int k = 0; k < 4; k++)
        begin
            v = w[k] * gain;
            if (sh_speed_loop)
                v = v * MAX_WHEEL_SPEED;
            v = rnd_shift(v, FRAC_BITS);
            if (sh_invert[k])
                v = -v;
            res.wheel[k] = v[OUT_W-1:0];
        end
        res.spd = sh_speed_loop;
        return res;
    endfunction

    // ---------------- checking ----------------

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    // Predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        wheel_set_t want;
        logic signed [OUT_W-1:0] got [4];
        string names [4];
        if (rst_n)
        begin
            names = '{"front_left", "front_right", "rear_left", "rear_right"};
            if (in_valid && in_ready)
            begin
                want = mix_request(x_speed, y_speed, turn_rate, gyro_angle);
                if (typed_en)
                begin
                    for (int k = 0; k < 4; k++)
                        want.wheel[k] = typed_val[OUT_W-1:0];
                    want.spd = 1'b1;
                end
                wheel_q.push_back(want);
                modes_seen[sh_mode] = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                res_cnt++;
                got = '{front_left_value, front_right_value,
                        rear_left_value, rear_right_value};
                if (wheel_q.size() == 0)
                    report("result with no request pending", 0, 0);
                else
                begin
                    want = wheel_q.pop_front();
                    for (int k = 0; k < 4; k++)
                        if (got[k] !== want.wheel[k])
                            report(names[k], got[k], want.wheel[k]);
                    if (to_speed_loop !== want.spd)
                        report("to_speed_loop", to_speed_loop, want.spd);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake, configuration write or reset
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en || !rst_n)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT)
        begin
            $display("timeout: no traffic for %0d cycles", IDLE_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // ---------------- receiver ----------------

    always @(posedge clk)
    begin
        int hold_cnt;
        int stall;
        int pick;
        if (hold_req)
        begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else if (no_idle)
            out_ready <= 1'b1;
        else if (stall > 0)
        begin
            stall--;
            out_ready <= 1'b0;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                stall = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    // ---------------- sender ----------------

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(logic [15:0] xs, logic [15:0] ys, logic [15:0] rs,
                                logic [15:0] ga, bit typed, int val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        x_speed    <= xs;
        y_speed    <= ys;
        turn_rate  <= rs;
        gyro_angle <= ga;
        typed_en   <= typed;
        typed_val  <= val;
        do
            @(posedge clk);
        while (!in_ready);
        req_cnt++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        // spare indexes are ignored by the block
        case (idx)
            CFG_SQUARED_INPUTS:  sh_squared    = val[0];
            CFG_DEADBAND:        sh_deadband   = val;
            CFG_DRIVE_MODE:      sh_mode       = val[2:0];
            CFG_SPEED_LOOP_MODE: sh_speed_loop = val[0];
            CFG_INVERT_MASK:     sh_invert     = val[3:0];
            CFG_MAX_OUTPUT:      sh_gain       = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (wheel_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_axis();
        logic [15:0] picks [5];
        picks = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        if ($urandom_range(0, 9) == 0)
            return picks[$urandom_range(0, 4)];
        return 16'($urandom);
    endfunction

    // ---------------- main sequence ----------------

    initial
    begin
        stim_row_t rows [14];
        logic [15:0] db;
        logic [15:0] gn;
        rows = '{
            '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0},
            '{16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 1, 2916263},
            '{16'h0000, 16'h0000, 16'h8000, 16'h0000, 1, -2916352},
            '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 0, 0},
            '{16'h8000, 16'h0000, 16'h0000, 16'h0000, 0, 0},
            '{16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 0, 0},
            '{16'h0000, 16'h8000, 16'h0000, 16'h4000, 0, 0},
            '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h2000, 0, 0},
            '{16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 0, 0},
            '{16'h5A5A, 16'hA5A5, 16'h1234, 16'h8000, 0, 0},
            '{16'h0001, 16'hFFFF, 16'h0000, 16'hC000, 0, 0},
            '{16'h4000, 16'hC000, 16'h2000, 16'h3FFF, 0, 0},
            '{16'h7FFF, 16'h8000, 16'h0000, 16'h0200, 0, 0},
            '{16'h0001, 16'h0001, 16'h0001, 16'h01FF, 0, 0}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under reset configuration
        foreach (rows[i])
            send_request(rows[i].x, rows[i].y, rows[i].r, rows[i].g,
                         rows[i].typed, rows[i].val);
        typed_en <= 1'b0;
        drain();

        // random phases, each with its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 9))
                0:       db = 16'($urandom);
                1, 2, 3: db = $urandom_range(0, 3000);
                default: db = '0;
            endcase
            gn = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
            if (ph == 0)
            begin
                write_reg(CFG_SQUARED_INPUTS, 16'd0);
                write_reg(CFG_DEADBAND, 16'd0);
                write_reg(CFG_DRIVE_MODE, 16'(MODE_OMNI));
                write_reg(CFG_SPEED_LOOP_MODE, 16'd0);
                write_reg(CFG_INVERT_MASK, 16'd0);
                write_reg(CFG_MAX_OUTPUT, 16'd0);
            end
            else if (ph == 1)
            begin
                // every setting at its top but the drive mode, deadband above one included
                write_reg(CFG_SQUARED_INPUTS, 16'd1);
                write_reg(CFG_DEADBAND, 16'hFFFF);
                write_reg(CFG_DRIVE_MODE, 16'(MODE_STRAFE));
                write_reg(CFG_SPEED_LOOP_MODE, 16'd1);
                write_reg(CFG_INVERT_MASK, 16'hF);
                write_reg(CFG_MAX_OUTPUT, 16'hFFFF);
            end
            else
            begin
                write_reg(CFG_SQUARED_INPUTS, 16'($urandom_range(0, 1)));
                write_reg(CFG_DEADBAND, (ph == 2) ? 16'd32768 : db);
                write_reg(CFG_DRIVE_MODE,
                          (ph == 7) ? 16'(MODE_UNUSED) :
                          (ph < 7)  ? 16'(ph) : 16'($urandom_range(0, 7)));
                write_reg(CFG_SPEED_LOOP_MODE, 16'($urandom_range(0, 1)));
                write_reg(CFG_INVERT_MASK, 16'($urandom_range(0, 15)));
                write_reg(CFG_MAX_OUTPUT, (ph == 3) ? 16'd32768 : gn);
            end
            write_reg(CFG_SPARE_LO, 16'($urandom));
            write_reg(CFG_SPARE_HI, 16'($urandom));

            // back to back in phases 4 and 9; in phase 4 the output is also held off, so the pipe fills
            no_idle = (ph == 4) || (ph == 9);
            if (ph == 4)
                hold_req = 1'b1;
            for (int i = 0; i < REQS_PER_PHASE; i++)
                send_request(rand_axis(), rand_axis(), rand_axis(), 16'($urandom), 0, 0);
            no_idle = 1'b0;
            drain();
        end

        repeat (60) @(posedge clk);
        if (wheel_q.size() != 0)
            report("requests left without result", wheel_q.size(), 0);
        $display("covered %0d requests, %0d results, drive modes seen %b,", req_cnt, res_cnt,
                 modes_seen);
        $display("extreme settings, spare register writes and a full-pipe stall");
        if (err_cnt == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
